// File: design/json_member_value_extractor_top_defines.svh
// Assertion macros used by the JSON member value extractor scanner.
`ifndef JSON_MEMBER_VALUE_EXTRACTOR_TOP_DEFINES_SVH
`define JSON_MEMBER_VALUE_EXTRACTOR_TOP_DEFINES_SVH

// Checks a condition in the same cycle as its trigger.
`define JMVE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a condition in the cycle after its trigger.
`define JMVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/jmve_pkg.sv
// Types and constants shared by the JSON member value extractor.
`timescale 1ns / 1ps

package jmve_pkg;

  typedef struct packed {
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
  } cfg_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_HT     = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;

  localparam logic [2:0] ST_NOT_FOUND = 3'd0;
  localparam logic [2:0] ST_STRING    = 3'd1;
  localparam logic [2:0] ST_INTEGER   = 3'd2;
  localparam logic [2:0] ST_BAD       = 3'd3;
  localparam logic [2:0] ST_UNTERM    = 3'd4;

  localparam logic [63:0] MAG_LIMIT_DIV = 64'd922337203685477580;

  localparam logic REG_KEY_BYTES  = 1'b0;
  localparam logic REG_KEY_LENGTH = 1'b1;

endpackage

// File: design/jmve_cfg_regs.sv
// Configuration register file with an APB-style write and read port.
`timescale 1ns / 1ps

module jmve_cfg_regs
  import jmve_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [63:0] key_bytes_r;
  logic [3:0]  key_length_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r  <= '0;
      key_length_r <= '0;
    end else if (wr_en) begin
      if (paddr[3] == REG_KEY_LENGTH) begin
        key_length_r <= pwdata[3:0];
      end else begin
        key_bytes_r <= pwdata;
      end
    end
  end

  always_comb begin
    if (paddr[3] == REG_KEY_LENGTH) begin
      prdata = {60'd0, key_length_r};
    end else begin
      prdata = key_bytes_r;
    end
  end

  assign cfg.key_bytes  = key_bytes_r;
  assign cfg.key_length = key_length_r;

endmodule

// File: design/jmve_scanner.sv
// Member scanner state machine with its result register.
`timescale 1ns / 1ps

module jmve_scanner
  import jmve_pkg::*;
#(
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        in_ready,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_vvalid,
  output logic        out_last,
  output logic [2:0]  out_status,
  output logic [63:0] out_int
);

`include "json_member_value_extractor_top_defines.svh"

  typedef enum logic [3:0] {
    PH_OPEN, PH_KEY_WS, PH_KEY, PH_COLON, PH_VAL_WS, PH_STR_VAL, PH_INT_DIG,
    PH_SKIP_WS, PH_SKIP_STR, PH_SKIP_SCALAR, PH_AFTER, PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  key_idx_r, key_idx_nxt;
  logic        key_mis_r, key_mis_nxt;
  logic        esc_r, esc_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;
  logic        dig_r, dig_nxt;
  logic [2:0]  fstat_r, fstat_nxt;

  logic        out_valid_r;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_vvalid_r, out_vvalid_nxt;
  logic        out_last_r;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [63:0] out_int_r, out_int_nxt;

  logic        adv;
  logic        is_ws, is_dig, is_end, key_hit, fin;
  logic [63:0] d64, mag10, acc10;

  assign adv      = in_valid && (!out_valid_r || out_ready);
  assign in_ready = !out_valid_r || out_ready;

  assign is_ws  = (in_byte == CH_SP) || (in_byte == CH_HT) ||
                  (in_byte == CH_LF) || (in_byte == CH_CR);
  assign is_dig = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign is_end = (in_byte == CH_COMMA) || (in_byte == CH_RBRACE) ||
                  (in_byte == CH_RBRACK);
  assign key_hit = (key_idx_r < cfg.key_length) && (key_idx_r < 4'(MAX_KEY_BYTES)) &&
                   (cfg.key_bytes[{key_idx_r[2:0], 3'b000} +: 8] == in_byte);

  assign d64   = {60'd0, in_byte[3:0]};
  assign mag10 = (mag_r << 3) + (mag_r << 1) + d64;
  assign acc10 = (acc_r << 3) + (acc_r << 1) + (neg_r ? (64'd0 - d64) : d64);

  always_comb begin
    phase_nxt      = phase_r;
    key_idx_nxt    = key_idx_r;
    key_mis_nxt    = key_mis_r;
    esc_nxt        = esc_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    acc_nxt        = acc_r;
    ovf_nxt        = ovf_r;
    dig_nxt        = dig_r;
    fstat_nxt      = fstat_r;
    out_byte_nxt   = 8'd0;
    out_vvalid_nxt = 1'b0;
    fin            = 1'b0;
    out_status_nxt = ST_NOT_FOUND;
    out_int_nxt    = 64'd0;

    case (phase_r)
      PH_OPEN: begin
        if (!is_ws) begin
          if (in_byte == CH_LBRACE) begin
            phase_nxt = PH_KEY_WS;
          end else begin
            fstat_nxt = ST_NOT_FOUND;
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_KEY_WS: begin
        if (!is_ws) begin
          if (in_byte == CH_QUOTE) begin
            key_idx_nxt = 4'd0;
            key_mis_nxt = 1'b0;
            esc_nxt     = 1'b0;
            phase_nxt   = PH_KEY;
          end else begin
            fstat_nxt = ST_NOT_FOUND;
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_KEY: begin
        if (!esc_r && in_byte == CH_QUOTE) begin
          if (key_idx_r != cfg.key_length) begin
            key_mis_nxt = 1'b1;
          end
          phase_nxt = PH_COLON;
        end else begin
          esc_nxt = !esc_r && (in_byte == CH_BSLASH);
          if (!key_mis_r) begin
            if (key_hit) begin
              key_idx_nxt = key_idx_r + 4'd1;
            end else begin
              key_mis_nxt = 1'b1;
            end
          end
        end
      end
      PH_COLON: begin
        if (!is_ws) begin
          if (in_byte == CH_COLON) begin
            phase_nxt = key_mis_r ? PH_SKIP_WS : PH_VAL_WS;
          end else begin
            fstat_nxt = ST_NOT_FOUND;
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_VAL_WS: begin
        if (!is_ws) begin
          if (in_byte == CH_QUOTE) begin
            esc_nxt   = 1'b0;
            phase_nxt = PH_STR_VAL;
          end else if (in_byte == CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_INT_DIG;
          end else if (is_dig) begin
            dig_nxt   = 1'b1;
            mag_nxt   = d64;
            acc_nxt   = d64;
            phase_nxt = PH_INT_DIG;
          end else begin
            fstat_nxt = ST_BAD;
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_STR_VAL: begin
        if (esc_r) begin
          esc_nxt        = 1'b0;
          out_vvalid_nxt = 1'b1;
          case (in_byte)
            CH_LC_B: out_byte_nxt = CH_BS;
            CH_LC_F: out_byte_nxt = CH_FF;
            CH_LC_N: out_byte_nxt = CH_LF;
            CH_LC_R: out_byte_nxt = CH_CR;
            CH_LC_T: out_byte_nxt = CH_HT;
            default: out_byte_nxt = in_byte;
          endcase
        end else if (in_byte == CH_QUOTE) begin
          fstat_nxt = ST_STRING;
          phase_nxt = PH_DONE;
        end else if (in_byte == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else begin
          out_byte_nxt   = in_byte;
          out_vvalid_nxt = 1'b1;
        end
      end
      PH_INT_DIG: begin
        if (is_dig) begin
          dig_nxt = 1'b1;
          if (!ovf_r) begin
            if ((mag_r > MAG_LIMIT_DIV) ||
                ((mag_r == MAG_LIMIT_DIV) && (in_byte[3:0] > 4'd8))) begin
              ovf_nxt = 1'b1;
            end else begin
              mag_nxt = mag10;
              acc_nxt = acc10;
            end
          end
        end else begin
          fin = 1'b1;
        end
      end
      PH_SKIP_WS: begin
        if (!is_ws) begin
          if (in_byte == CH_QUOTE) begin
            esc_nxt   = 1'b0;
            phase_nxt = PH_SKIP_STR;
          end else if (is_end) begin
            if (in_byte == CH_COMMA) begin
              phase_nxt = PH_KEY_WS;
            end else begin
              fstat_nxt = ST_NOT_FOUND;
              phase_nxt = PH_DONE;
            end
          end else begin
            phase_nxt = PH_SKIP_SCALAR;
          end
        end
      end
      PH_SKIP_STR: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (in_byte == CH_QUOTE) begin
          phase_nxt = PH_AFTER;
        end else if (in_byte == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end
      end
      PH_SKIP_SCALAR: begin
        if (is_ws) begin
          phase_nxt = PH_AFTER;
        end else if (is_end) begin
          if (in_byte == CH_COMMA) begin
            phase_nxt = PH_KEY_WS;
          end else begin
            fstat_nxt = ST_NOT_FOUND;
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_AFTER: begin
        if (!is_ws) begin
          if (in_byte == CH_COMMA) begin
            phase_nxt = PH_KEY_WS;
          end else begin
            fstat_nxt = ST_NOT_FOUND;
            phase_nxt = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase

    // An integer ends at its first non-digit or at the end of the text.
    if (fin || (in_last && phase_nxt == PH_INT_DIG)) begin
      if (!dig_nxt || ovf_nxt || (!neg_nxt && mag_nxt[63])) begin
        fstat_nxt = ST_BAD;
      end else begin
        fstat_nxt = ST_INTEGER;
      end
      phase_nxt = PH_DONE;
    end

    if (in_last) begin
      case (phase_nxt)
        PH_DONE:    out_status_nxt = fstat_nxt;
        PH_STR_VAL: out_status_nxt = ST_UNTERM;
        PH_VAL_WS:  out_status_nxt = ST_BAD;
        default:    out_status_nxt = ST_NOT_FOUND;
      endcase
      if (out_status_nxt == ST_INTEGER) begin
        out_int_nxt = acc_nxt;
      end
      phase_nxt   = PH_OPEN;
      key_idx_nxt = 4'd0;
      key_mis_nxt = 1'b0;
      esc_nxt     = 1'b0;
      neg_nxt     = 1'b0;
      mag_nxt     = 64'd0;
      acc_nxt     = 64'd0;
      ovf_nxt     = 1'b0;
      dig_nxt     = 1'b0;
      fstat_nxt   = ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPEN;
      key_idx_r   <= '0;
      key_mis_r   <= 1'b0;
      esc_r       <= 1'b0;
      neg_r       <= 1'b0;
      mag_r       <= '0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      dig_r       <= 1'b0;
      fstat_r     <= ST_NOT_FOUND;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        phase_r      <= phase_nxt;
        key_idx_r    <= key_idx_nxt;
        key_mis_r    <= key_mis_nxt;
        esc_r        <= esc_nxt;
        neg_r        <= neg_nxt;
        mag_r        <= mag_nxt;
        acc_r        <= acc_nxt;
        ovf_r        <= ovf_nxt;
        dig_r        <= dig_nxt;
        fstat_r      <= fstat_nxt;
        out_valid_r  <= 1'b1;
        out_byte_r   <= out_byte_nxt;
        out_vvalid_r <= out_vvalid_nxt;
        out_last_r   <= in_last;
        out_status_r <= out_status_nxt;
        out_int_r    <= out_int_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_vvalid = out_vvalid_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;
  assign out_int    = out_int_r;

  `JMVE_ASSERT_NOW(a_status_only_at_end, out_valid_r && !out_last_r,
    out_status_r == ST_NOT_FOUND, "status reported before the last word")
  `JMVE_ASSERT_NOW(a_int_only_for_integer, out_valid_r && out_status_r != ST_INTEGER,
    out_int_r == 64'd0, "integer value without integer status")
  `JMVE_ASSERT_NOW(a_byte_at_end_unterm, out_valid_r && out_vvalid_r && out_last_r,
    out_status_r == ST_UNTERM, "value byte on the last word must mean unterminated")
  `JMVE_ASSERT_NEXT(a_clear_after_last, adv && in_last,
    phase_r == PH_OPEN && !neg_r && !ovf_r && !dig_r, "scan state not cleared")

endmodule

// File: design/json_member_value_extractor_top.sv
// Top level of the JSON member value extractor.
//
//  Port group  Direction  Carries
//  in_*        slave      one text byte per word, tlast on the final byte
//  out_*       master     one result word per text byte, tlast on the final one
//  cfg_*       APB        key_bytes at 0x0, key_length at 0x8
//
// One byte is taken per cycle unless the output stalls; the scanner state machine updates once per accepted byte.
// An accepted byte passes through the input register and then the result register to the output.
// Reset is synchronous on rst_n and clears the scan state and both stages.
// A stalled output holds its word; the input register still fills while it is empty.
`timescale 1ns / 1ps

module json_member_value_extractor_top
  import jmve_pkg::*;
#(
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // text_byte
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // value_byte, status, integer_value, zero pad
  output logic        out_tuser,  // value_valid
  output logic        out_tlast,  // done_res
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t        cfg;
  logic        s_valid_r;
  logic [7:0]  s_byte_r;
  logic        s_last_r;
  logic        s_ready;
  logic [7:0]  r_byte;
  logic [2:0]  r_status;
  logic [63:0] r_int;

  jmve_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign in_tready = !s_valid_r || s_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s_valid_r <= in_tvalid;
      end
      if (in_tvalid && in_tready) begin
        s_byte_r <= in_tdata;
        s_last_r <= in_tlast;
      end
    end
  end

  jmve_scanner #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (s_valid_r),
    .in_byte    (s_byte_r),
    .in_last    (s_last_r),
    .in_ready   (s_ready),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_byte   (r_byte),
    .out_vvalid (out_tuser),
    .out_last   (out_tlast),
    .out_status (r_status),
    .out_int    (r_int)
  );

  assign out_tdata = {5'd0, r_int, r_status, r_byte};

endmodule
